[design/pbu_pkg.sv]
// Shared types, codes and constants for the polyBLEP unison oscillator.
package pbu_pkg;

  localparam int MAX_VOICES_DEF      = 16;
  localparam int PHASE_BITS_DEF      = 24;
  localparam int SINE_TABLE_BITS_DEF = 10;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_LOAD_INC = 2'd1,
    OP_LOAD_PH  = 2'd2,
    OP_NONE     = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    REG_WAVE_SHAPE  = 3'd0,
    REG_PULSE_WIDTH = 3'd1,
    REG_VOICE_COUNT = 3'd2,
    REG_BLEND       = 3'd3,
    REG_OUT_LEVEL   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    WAVE_SINE  = 2'd0,
    WAVE_SAW   = 2'd1,
    WAVE_PULSE = 2'd2,
    WAVE_TRI   = 2'd3
  } wave_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_SIN_SQ,
    ST_SIN_X2,
    ST_SIN_HMUL,
    ST_SIN_HSUB,
    ST_SIN_XMUL,
    ST_SIN_FIN,
    ST_BLEP_START,
    ST_BLEP_DIV,
    ST_BLEP_MUL,
    ST_BLEP_FIN,
    ST_WMUL,
    ST_WACC,
    ST_FIN_LO,
    ST_FIN_HI,
    ST_FIN_SUM,
    ST_FIN_DIV,
    ST_FIN_OUT
  } state_t;

  localparam logic [30:0] SINE_SEED = 31'd3864;

  // Horner coefficients of the quarter-wave sine polynomial, Q30.
  function automatic logic [30:0] horner_c(input logic [2:0] idx);
    logic [30:0] c;
    case (idx)
      3'd0:    c = 31'd172272;
      3'd1:    c = 31'd5026995;
      3'd2:    c = 31'd85569306;
      3'd3:    c = 31'd693598668;
      3'd4:    c = 31'd1686629713;
      default: c = 31'd0;
    endcase
    return c;
  endfunction

endpackage

[design/polyblep_unison_oscillator.sv]
// Top level of the polyBLEP unison oscillator: sequencer, shared multiplier and divider.
//
// Usage: the input channel (in_valid/in_stall) carries opcode, voice and value.
// A tick transaction runs every active voice through one shared multiplier and one
// shared radix-2 divider and then produces one sample on the output channel
// (out_valid/out_stall). Load transactions write a voice increment or phase
// and produce nothing. Configuration writes use cfg_valid/cfg_ready,
// which is always ready, and should happen only while the block is idle.
// A tick ends with the final gain, the division by the voice count and the output
// register; a sawtooth or pulse voice skips the polyBLEP division when no edge is
// near, and that division runs 15 steps of the shared divider.
// in_stall is high from the accepted tick until its sample sits in the output
// register; a sample waiting on a stalled receiver does not block loads, and a
// following tick finishes its voices and waits for the output register.
// Reset is synchronous: state, out_valid and the configuration registers take their defaults
// and all voice phases and increments read as zero; no clearing pass is needed.
module polyblep_unison_oscillator #(
  parameter int MAX_VOICES      = pbu_pkg::MAX_VOICES_DEF,
  parameter int PHASE_BITS      = pbu_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = pbu_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [3:0]         voice,
  input  logic [23:0]        value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] sample,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import pbu_pkg::*;

  localparam int PB     = PHASE_BITS;
  localparam int STB    = SINE_TABLE_BITS;
  localparam int VW     = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CW     = $clog2(MAX_VOICES + 1);
  localparam int ACC_W  = 34 + $clog2(MAX_VOICES) + 1;
  localparam int TW     = ACC_W + 16;
  localparam int QW     = ACC_W - 14;
  localparam int DCW    = $clog2(QW + 1);
  localparam int HI_W   = ACC_W - 24;

  state_t state, state_next;

  // Configuration registers.
  logic [1:0]    wave_shape;
  logic [15:0]   pulse_width;
  logic [CW-1:0] voice_count;
  logic [15:0]   blend;
  logic [15:0]   out_level;

  // Voice stores with valid bits so unwritten entries read as zero.
  logic [PB-1:0]         ph_mem  [MAX_VOICES];
  logic [PB-1:0]         inc_mem [MAX_VOICES];
  logic [MAX_VOICES-1:0] ph_vld;
  logic [MAX_VOICES-1:0] inc_vld;
  logic [PB-1:0]         rd_ph, rd_inc;
  logic                  rd_ph_vld, rd_inc_vld;

  // Datapath registers.
  logic [VW-1:0]            vidx;
  logic [CW-1:0]            n_r;
  logic [PB-1:0]            p_r, d_r, bp;
  logic                     pass, bbr, bzero;
  logic signed [17:0]       b1, wval;
  logic [30:0]              sx, x2, sa;
  logic                     sneg;
  logic [2:0]               hcnt;
  logic signed [ACC_W-1:0]  acc;
  logic [TW-1:0]            tot;
  logic [PB:0]              div_r;
  logic [QW-1:0]            div_q;
  logic [PB-1:0]            div_d;
  logic [DCW-1:0]           div_cnt;
  logic signed [65:0]       mul_r;
  logic signed [32:0]       mul_a, mul_b;

  logic in_acc;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  logic [PB-1:0] val_in;
  logic [VW-1:0] ld_addr;
  logic          ld_ok;
  assign val_in  = PB'(value);
  assign ld_addr = VW'(voice);
  assign ld_ok   = (int'(voice) < MAX_VOICES);

  // Read data with the valid masks applied.
  logic [PB-1:0] p_cur, d_cur;
  assign p_cur = rd_ph_vld ? rd_ph : '0;
  assign d_cur = rd_inc_vld ? rd_inc : '0;

  // Waveform pieces.
  logic [PB+STB-1:0] kw;
  logic [STB-1:0]    k;
  logic [STB-2:0]    f;
  logic [PB+16:0]    saw_w;
  logic [PB+16:0]    tri_w;
  logic [16:0]       tri_q;
  logic [PB+15:0]    pw_w;
  logic [PB-1:0]     pw;
  logic signed [17:0] tri_v, saw_v, pulse_base, bv;
  assign kw    = {p_cur, {STB{1'b0}}} >> PB;
  assign k     = kw[STB-1:0];
  assign f     = k[STB-2] ? ((STB-1)'(1) << (STB-2)) - (STB-1)'(k[STB-3:0])
                          : (STB-1)'(k[STB-3:0]);
  assign tri_w = {p_cur, 17'b0} >> PB;
  assign tri_q = tri_w[16:0];
  assign tri_v = p_cur[PB-1] ? (18'sd98304 - $signed({1'b0, tri_q}))
                             : ($signed({1'b0, tri_q}) - 18'sd32768);
  assign saw_w = {1'b0, p_r, 16'b0} >> PB;
  assign saw_v = $signed({1'b0, saw_w[16:0]}) - 18'sd32768 - bv;
  assign pw_w  = {pulse_width, {PB{1'b0}}} >> 16;
  assign pw    = pw_w[PB-1:0];
  assign pulse_base = (p_r < pw) ? 18'sd32768 : -18'sd32768;

  // polyBLEP residual from the divider quotient and its square.
  logic [14:0] t_q;
  logic [15:0] tt;
  assign t_q = div_q[14:0];
  assign tt  = mul_r[30:15];
  assign bv  = bzero ? 18'sd0
             : bbr   ? $signed(18'(tt) - 18'({t_q, 1'b0}) + 18'd32768)
             :         $signed(18'({t_q, 1'b0}) - 18'(tt) - 18'd32768);

  logic [PB:0] one_minus;
  assign one_minus = ((PB+1)'(1) << PB) - (PB+1)'(bp);

  // Shared restoring divider step.
  logic [PB+1:0] rs, rs_sub;
  logic          ge;
  assign rs     = {div_r, div_q[QW-1]};
  assign ge     = rs >= {2'b0, div_d};
  assign rs_sub = rs - {2'b0, div_d};

  // Sine rounding.
  logic [30:0] sa_fin;
  logic [16:0] s_round;
  logic [16:0] s_mag;
  assign sa_fin  = mul_r[60:30];
  assign s_round = 17'((32'(sa_fin) + 32'd16384) >> 15);
  assign s_mag   = (s_round > 17'd32768) ? 17'd32768 : s_round;

  // Voice weight.
  logic [16:0] weight;
  always_comb begin
    if (n_r == CW'(1)) begin
      weight = 17'd32768;
    end else if (CW'(vidx) == (n_r >> 1)) begin
      weight = 17'd32768 - 17'(blend);
    end else begin
      weight = 17'(blend);
    end
  end

  // Magnitude of the mix for the gain multiply.
  logic              acc_neg;
  logic [ACC_W-1:0]  mag;
  logic [TW-1:0]     tot_sum;
  assign acc_neg = acc[ACC_W-1];
  assign mag     = acc_neg ? ACC_W'(-acc) : ACC_W'(acc);
  assign tot_sum = tot + (TW'(mul_r[HI_W+15:0]) << 24);

  // Final sign and saturation.
  logic signed [17:0] sat_v;
  always_comb begin
    if (acc_neg) begin
      sat_v = (div_q > QW'(65536)) ? -18'sd65536 : -$signed(18'(div_q));
    end else begin
      sat_v = (div_q > QW'(65535)) ? 18'sd65535 : $signed(18'(div_q));
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SIN_SQ: begin
        mul_a = $signed(33'(sx));
        mul_b = $signed(33'(sx));
      end
      ST_SIN_HMUL: begin
        mul_a = $signed(33'(x2));
        mul_b = $signed(33'(sa));
      end
      ST_SIN_XMUL: begin
        mul_a = $signed(33'(sx));
        mul_b = $signed(33'(sa));
      end
      ST_BLEP_MUL: begin
        mul_a = $signed(33'(t_q));
        mul_b = $signed(33'(t_q));
      end
      ST_WMUL: begin
        mul_a = 33'(wval);
        mul_b = $signed(33'(weight));
      end
      ST_FIN_LO: begin
        mul_a = $signed(33'(mag[23:0]));
        mul_b = $signed(33'(out_level));
      end
      ST_FIN_HI: begin
        mul_a = $signed(33'(mag[ACC_W-1:24]));
        mul_b = $signed(33'(out_level));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && opcode == OP_TICK) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_LOAD;
      ST_LOAD: begin
        case (wave_shape)
          WAVE_SINE: state_next = ST_SIN_SQ;
          WAVE_TRI:  state_next = ST_WMUL;
          default:   state_next = ST_BLEP_START;
        endcase
      end
      ST_SIN_SQ:   state_next = ST_SIN_X2;
      ST_SIN_X2:   state_next = ST_SIN_HMUL;
      ST_SIN_HMUL: state_next = ST_SIN_HSUB;
      ST_SIN_HSUB: state_next = (hcnt == 3'd4) ? ST_SIN_XMUL : ST_SIN_HMUL;
      ST_SIN_XMUL: state_next = ST_SIN_FIN;
      ST_SIN_FIN:  state_next = ST_WMUL;
      ST_BLEP_START: begin
        if (d_r == '0 || (bp >= d_r && one_minus >= (PB+1)'(d_r))) begin
          state_next = ST_BLEP_FIN;
        end else begin
          state_next = ST_BLEP_DIV;
        end
      end
      ST_BLEP_DIV: state_next = (div_cnt == DCW'(1)) ? ST_BLEP_MUL : ST_BLEP_DIV;
      ST_BLEP_MUL: state_next = ST_BLEP_FIN;
      ST_BLEP_FIN: begin
        if (wave_shape == WAVE_PULSE && !pass) begin
          state_next = ST_BLEP_START;
        end else begin
          state_next = ST_WMUL;
        end
      end
      ST_WMUL: state_next = ST_WACC;
      ST_WACC: state_next = (CW'(vidx) == n_r - CW'(1)) ? ST_FIN_LO : ST_READ;
      ST_FIN_LO:  state_next = ST_FIN_HI;
      ST_FIN_HI:  state_next = ST_FIN_SUM;
      ST_FIN_SUM: state_next = ST_FIN_DIV;
      ST_FIN_DIV: state_next = (div_cnt == DCW'(1)) ? ST_FIN_OUT : ST_FIN_DIV;
      ST_FIN_OUT: begin
        if (!(out_valid && out_stall)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers; writes saturate to their legal range, the voice count from cfg_data[4:0] only.
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_shape  <= WAVE_SINE;
      pulse_width <= 16'd32768;
      voice_count <= CW'(1);
      blend       <= 16'd16384;
      out_level   <= 16'd32768;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WAVE_SHAPE: wave_shape <= cfg_data[1:0];
        REG_PULSE_WIDTH: begin
          if (cfg_data < 16'd655) begin
            pulse_width <= 16'd655;
          end else if (cfg_data > 16'd64880) begin
            pulse_width <= 16'd64880;
          end else begin
            pulse_width <= cfg_data;
          end
        end
        REG_VOICE_COUNT: begin
          if (cfg_data[4:0] == 5'd0) begin
            voice_count <= CW'(1);
          end else if (int'(cfg_data[4:0]) > MAX_VOICES) begin
            voice_count <= CW'(MAX_VOICES);
          end else begin
            voice_count <= CW'(cfg_data[4:0]);
          end
        end
        REG_BLEND:     blend     <= (cfg_data > 16'd32768) ? 16'd32768 : cfg_data;
        REG_OUT_LEVEL: out_level <= (cfg_data > 16'd32768) ? 16'd32768 : cfg_data;
        default: ;
      endcase
    end
  end

  // Voice stores: host loads while idle, phase write-back during a tick.
  logic          ph_we, inc_we;
  logic [VW-1:0] ph_wa;
  logic [PB-1:0] ph_wd;
  always_comb begin
    ph_we  = 1'b0;
    inc_we = 1'b0;
    ph_wa  = ld_addr;
    ph_wd  = val_in;
    if (state == ST_LOAD) begin
      ph_we = 1'b1;
      ph_wa = vidx;
      ph_wd = p_cur + d_cur;
    end else if (in_acc && ld_ok) begin
      ph_we  = (opcode == OP_LOAD_PH);
      inc_we = (opcode == OP_LOAD_INC);
    end
  end

  always_ff @(posedge clk) begin
    if (ph_we) begin
      ph_mem[ph_wa] <= ph_wd;
    end
    if (inc_we) begin
      inc_mem[ld_addr] <= val_in;
    end
    rd_ph  <= ph_mem[vidx];
    rd_inc <= inc_mem[vidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph_vld  <= '0;
      inc_vld <= '0;
    end else begin
      if (ph_we) begin
        ph_vld[ph_wa] <= 1'b1;
      end
      if (inc_we) begin
        inc_vld[ld_addr] <= 1'b1;
      end
    end
    rd_ph_vld  <= ph_vld[vidx];
    rd_inc_vld <= inc_vld[vidx];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN_OUT && !(out_valid && out_stall)) begin
      out_valid <= 1'b1;
      sample    <= 17'(sat_v);
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        vidx <= '0;
        acc  <= '0;
        n_r  <= voice_count;
      end
      ST_LOAD: begin
        p_r  <= p_cur;
        d_r  <= d_cur;
        bp   <= p_cur;
        pass <= 1'b0;
        sx   <= 31'(f) << (32 - STB);
        sneg <= k[STB-1];
        wval <= tri_v;
      end
      ST_SIN_X2: begin
        x2   <= mul_r[60:30];
        sa   <= SINE_SEED;
        hcnt <= 3'd0;
      end
      ST_SIN_HSUB: begin
        sa   <= horner_c(hcnt) - mul_r[60:30];
        hcnt <= hcnt + 3'd1;
      end
      ST_SIN_FIN: begin
        wval <= sneg ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
      end
      ST_BLEP_START: begin
        bzero   <= (d_r == '0 || (bp >= d_r && one_minus >= (PB+1)'(d_r)));
        bbr     <= (bp >= d_r);
        div_r   <= (bp < d_r) ? (PB+1)'(bp) : one_minus;
        div_q   <= '0;
        div_d   <= d_r;
        div_cnt <= DCW'(15);
      end
      ST_BLEP_DIV, ST_FIN_DIV: begin
        div_r   <= ge ? rs_sub[PB:0] : rs[PB:0];
        div_q   <= {div_q[QW-2:0], ge};
        div_cnt <= div_cnt - DCW'(1);
      end
      ST_BLEP_FIN: begin
        if (wave_shape == WAVE_SAW) begin
          wval <= saw_v;
        end else if (!pass) begin
          b1   <= bv;
          bp   <= p_r - pw;
          pass <= 1'b1;
        end else begin
          wval <= pulse_base + b1 - bv;
        end
      end
      ST_WACC: begin
        acc  <= acc + mul_r[ACC_W-1:0];
        vidx <= vidx + VW'(1);
      end
      ST_FIN_HI: begin
        tot <= TW'(mul_r[39:0]);
      end
      ST_FIN_SUM: begin
        div_r   <= '0;
        div_q   <= tot_sum[TW-1:30];
        div_d   <= PB'(n_r);
        div_cnt <= DCW'(QW);
      end
      default: ;
    endcase
  end

endmodule
